// File: src/pbfa_pkg.sv
// Package with the beat types and fixed constants of the page bitmap allocator.
package pbfa_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int SIZE_W = 19;
    localparam int OFFSET_W = 18;
    localparam int MIN_PAGES_W = 7;
    localparam int NEED_W = 8;

    localparam logic [MIN_PAGES_W-1:0] MIN_PAGES_RESET = 7'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SIZE_W-1:0]   size_bytes;
        logic [OFFSET_W-1:0] offset_bytes;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [OFFSET_W-1:0] start_offset;
        logic [SIZE_W-1:0]   granted_bytes;
    } rsp_t;

endpackage

// File: src/page_bitmap_first_fit_allocator.sv
// Top level of the page bitmap first-fit allocator with its rotating page bitmap.
//
// The block keeps one committed bit per page of 4096 bytes in a ring shift
// register that turns by one page per clock while busy. A request beat is taken when start
// is high and busy is low. An allocate beat asks for one page more than the
// whole pages in its size, raises the count to at least min_pages, and searches
// the first free run long enough to hold it. A release beat clears whole pages
// from the page that holds its offset, clipped at the pool end.
// Every request gives exactly one result beat, shown on rsp for one cycle with
// done high. The receiver cannot stall, so the beat is simply taken there.
// A release takes one turn of the ring, a failed allocation one turn, and a
// successful one a search turn and a marking turn.
// The next start is taken in the cycle that done is shown.
// Reset sets the first INITIAL_PAGES pages committed and min_pages to four.
// The min_pages register is written with cfg_we and cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce this.
module page_bitmap_first_fit_allocator #(
    parameter int TOTAL_PAGES = 64,
    parameter int INITIAL_PAGES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pbfa_pkg::req_t                req,
    input  logic                          cfg_we,
    input  logic [pbfa_pkg::MIN_PAGES_W-1:0] cfg_wdata,
    output logic                          done,
    output pbfa_pkg::rsp_t                rsp
);
    import pbfa_pkg::*;

    localparam int PW = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
    localparam int CW = (PW + 1 > 9) ? PW + 1 : 9;
    localparam logic [PW-1:0] LAST_PAGE = PW'(TOTAL_PAGES - 1);

    function automatic logic [TOTAL_PAGES-1:0] init_mask();
        logic [TOTAL_PAGES-1:0] m;
        m = '0;
        for (int i = 0; i < TOTAL_PAGES; i++)
        begin
            m[i] = (i < INITIAL_PAGES);
        end
        return m;
    endfunction

    localparam logic [TOTAL_PAGES-1:0] INIT_MASK = init_mask();

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_RANGE  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [TOTAL_PAGES-1:0]  ring_reg, ring_next;
    logic [PW-1:0]           page_cnt_reg, page_cnt_next;
    logic [PW:0]             run_len_reg, run_len_next;
    logic [PW-1:0]           run_start_reg, run_start_next;
    logic [PW-1:0]           start_reg, start_next;
    logic                    found_reg, found_next;
    logic [NEED_W-1:0]       need_reg, need_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic                    range_val_reg, range_val_next;
    logic [MIN_PAGES_W-1:0]  min_pages_reg, min_pages_next;
    logic                    done_reg, done_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    accept;
    logic                    bit_cur;
    logic                    bit_new;
    logic                    last_page;
    logic [PW:0]             len_inc;
    logic [CW-1:0]           page_ext;
    logic [NEED_W-1:0]       need_raw;

    assign accept = start && (state_reg == ST_IDLE);
    assign bit_cur = ring_reg[0];
    assign last_page = (page_cnt_reg == LAST_PAGE);
    assign len_inc = run_len_reg + (PW+1)'(1);
    assign page_ext = CW'(page_cnt_reg);
    assign need_raw = NEED_W'(req.size_bytes[SIZE_W-1:PAGE_SHIFT]) + NEED_W'(1);

    always_comb
    begin
        state_next = state_reg;
        ring_next = ring_reg;
        page_cnt_next = page_cnt_reg;
        run_len_next = run_len_reg;
        run_start_next = run_start_reg;
        start_next = start_reg;
        found_next = found_reg;
        need_next = need_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        range_val_next = range_val_reg;
        min_pages_next = cfg_we ? cfg_wdata : min_pages_reg;
        done_next = 1'b0;
        rsp_next = rsp_reg;
        bit_new = bit_cur;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    page_cnt_next = '0;
                    run_len_next = '0;
                    found_next = 1'b0;
                    if (req.op == OP_ALLOC)
                    begin
                        state_next = ST_SEARCH;
                        if (need_raw < NEED_W'(min_pages_reg))
                        begin
                            need_next = NEED_W'(min_pages_reg);
                        end
                        else
                        begin
                            need_next = need_raw;
                        end
                    end
                    else
                    begin
                        state_next = ST_RANGE;
                        range_val_next = 1'b0;
                        lo_next = CW'(req.offset_bytes[OFFSET_W-1:PAGE_SHIFT]);
                        hi_next = CW'(req.offset_bytes[OFFSET_W-1:PAGE_SHIFT])
                                + CW'(req.size_bytes[SIZE_W-1:PAGE_SHIFT]);
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!bit_cur)
                begin
                    run_len_next = len_inc;
                    if (run_len_reg == '0)
                    begin
                        run_start_next = page_cnt_reg;
                    end
                    if (!found_reg && (CW'(len_inc) >= CW'(need_reg)))
                    begin
                        found_next = 1'b1;
                        start_next = (run_len_reg == '0) ? page_cnt_reg : run_start_reg;
                    end
                end
                else
                begin
                    run_len_next = '0;
                end
                ring_next = {bit_new, ring_reg[TOTAL_PAGES-1:1]};
                page_cnt_next = page_cnt_reg + PW'(1);
                if (last_page)
                begin
                    page_cnt_next = '0;
                    if (found_next)
                    begin
                        state_next = ST_RANGE;
                        range_val_next = 1'b1;
                        lo_next = CW'(start_next);
                        hi_next = CW'(start_next) + CW'(need_reg);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        done_next = 1'b1;
                        rsp_next = '0;
                    end
                end
            end
            ST_RANGE:
            begin
                if ((page_ext >= lo_reg) && (page_ext < hi_reg))
                begin
                    bit_new = range_val_reg;
                end
                ring_next = {bit_new, ring_reg[TOTAL_PAGES-1:1]};
                page_cnt_next = page_cnt_reg + PW'(1);
                if (last_page)
                begin
                    page_cnt_next = '0;
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                    rsp_next.ok = 1'b1;
                    if (range_val_reg)
                    begin
                        rsp_next.start_offset = OFFSET_W'({start_reg, {PAGE_SHIFT{1'b0}}});
                        rsp_next.granted_bytes = SIZE_W'({need_reg, {PAGE_SHIFT{1'b0}}});
                    end
                    else
                    begin
                        rsp_next.start_offset = '0;
                        rsp_next.granted_bytes = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ring_reg <= INIT_MASK;
            page_cnt_reg <= '0;
            found_reg <= 1'b0;
            min_pages_reg <= MIN_PAGES_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ring_reg <= ring_next;
            page_cnt_reg <= page_cnt_next;
            found_reg <= found_next;
            min_pages_reg <= min_pages_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_len_reg <= run_len_next;
        run_start_reg <= run_start_next;
        start_reg <= start_next;
        need_reg <= need_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        range_val_reg <= range_val_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp = rsp_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while the ring is still turning");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (page_cnt_reg == '0))
        else $error("ring not aligned to page zero while idle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> ((rsp.start_offset == '0) && (rsp.granted_bytes == '0)))
        else $error("failed allocation beat carries nonzero fields");

endmodule
